// ===== design/token_lexer_defines.svh =====
`ifndef TOKEN_LEXER_DEFINES_SVH
`define TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TLX_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TLX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tlex_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlex_pkg;

    // result kinds
    localparam logic [4:0] K_NUM    = 5'd0;
    localparam logic [4:0] K_INT    = 5'd1;
    localparam logic [4:0] K_IF     = 5'd2;
    localparam logic [4:0] K_ELSE   = 5'd3;
    localparam logic [4:0] K_NAME   = 5'd4;
    localparam logic [4:0] K_PLUS   = 5'd5;
    localparam logic [4:0] K_MINUS  = 5'd6;
    localparam logic [4:0] K_STAR   = 5'd7;
    localparam logic [4:0] K_SLASH  = 5'd8;
    localparam logic [4:0] K_LPAREN = 5'd9;
    localparam logic [4:0] K_RPAREN = 5'd10;
    localparam logic [4:0] K_LBRACE = 5'd11;
    localparam logic [4:0] K_RBRACE = 5'd12;
    localparam logic [4:0] K_ASSIGN = 5'd13;
    localparam logic [4:0] K_SEMI   = 5'd14;
    localparam logic [4:0] K_EOF    = 5'd15;
    localparam logic [4:0] K_ERROR  = 5'd16;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;

    // result bus layout: tdata = {name_char, number_value}, tuser = kind
    localparam int TDATA_W = 40;
    localparam int TUSER_W = 5;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_NAME = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CL_WS    = 2'd0,
        CL_DIG   = 2'd1,
        CL_ALPHA = 2'd2,
        CL_TOK   = 2'd3
    } cls_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input transaction taken
        logic tail_load;  // send the deferred single-byte token
        logic rd;         // read name buffer at the emit index
        logic emit;       // send one name character
        logic resume;     // process the held byte after a name spill
    } tlex_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;  // output register can take a result this cycle
        logic spill;      // current byte ends a plain name
        logic tail;       // current byte yields a second result
        logic emit_last;  // emit index is at the final character
    } tlex_stat_t;

    function automatic cls_t byte_class(input logic [7:0] b);
        cls_t c;
        if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
            c = CL_WS;
        end else if (b inside {[CH_ZERO:CH_NINE]}) begin
            c = CL_DIG;
        end else if (b inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]}) begin
            c = CL_ALPHA;
        end else begin
            c = CL_TOK;
        end
        return c;
    endfunction

    // kind of a single-byte token; anything unknown is an error
    function automatic logic [4:0] tok_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            CH_NUL:    k = K_EOF;
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_STAR;
            CH_SLASH:  k = K_SLASH;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_EQUAL:  k = K_ASSIGN;
            CH_SEMI:   k = K_SEMI;
            default:   k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== design/tlex_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  wire logic                                         aclk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/tlex_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlex_datapath import tlex_pkg::*; #(
    parameter int MAX_NAME = 31
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         s_tdata,
    input  wire tlex_cmd_t          cmd,
    output tlex_stat_t              stat,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [TUSER_W-1:0]      m_tuser,
    output logic                    m_tlast
);
    localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int LW = $clog2(MAX_NAME + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_NAME);

    // token state
    mode_t         mode_reg, mode_next;
    logic [31:0]   acc_reg, acc_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          halted_reg, halted_next;
    logic          kw_int_reg, kw_int_next;   // buffer so far matches a prefix of int
    logic          kw_if_reg, kw_if_next;
    logic          kw_else_reg, kw_else_next;
    logic [7:0]    hold_reg, hold_next;       // byte that ended a spilled name
    logic [4:0]    tail_reg, tail_next;       // deferred single-byte token

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [4:0]    out_kind_reg, out_kind_next;
    logic [31:0]   out_num_reg, out_num_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          out_last_reg, out_last_next;

    // name buffer port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    cls_t          in_cls, start_cls;
    logic          in_alnum, term_int;
    logic          cont_num, cont_name, flush_num, flush_name;
    logic          kw_hit, spill, slot_free, emit_last;
    logic [4:0]    kw_kind, start_tok;
    logic [7:0]    start_b;
    logic          start_en, start_to_tail;
    logic          load;
    logic [4:0]    ld_kind;
    logic [31:0]   ld_num;
    logic [7:0]    ld_char;
    logic          ld_last;

    tlex_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME)
    ) u_name_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // classify the incoming byte against the pending token
    always_comb begin
        in_cls     = byte_class(s_tdata);
        in_alnum   = (in_cls == CL_DIG) || (in_cls == CL_ALPHA);
        term_int   = (in_cls == CL_WS) || (s_tdata == CH_NUL) || (s_tdata == CH_SEMI)
                     || (s_tdata == CH_EQUAL);
        cont_num   = (mode_reg == MODE_NUM) && (in_cls == CL_DIG);
        flush_num  = (mode_reg == MODE_NUM) && (in_cls != CL_DIG);
        cont_name  = (mode_reg == MODE_NAME) && in_alnum && (len_reg < LEN_MAX);
        flush_name = (mode_reg == MODE_NAME) && !cont_name;

        kw_kind = K_NAME;
        kw_hit  = 1'b0;
        if (kw_int_reg && (len_reg == LW'(3)) && term_int) begin
            kw_kind = K_INT;
            kw_hit  = 1'b1;
        end else if (kw_if_reg && (len_reg == LW'(2)) && !in_alnum) begin
            kw_kind = K_IF;
            kw_hit  = 1'b1;
        end else if (kw_else_reg && (len_reg == LW'(4)) && !in_alnum) begin
            kw_kind = K_ELSE;
            kw_hit  = 1'b1;
        end
        spill = flush_name && !kw_hit;

        slot_free = !out_valid_reg || m_tready;
        emit_last = (LW'(idx_reg + LW'(1)) == len_reg);

        // a new token starts from the current byte or the held one
        start_b       = cmd.resume ? hold_reg : s_tdata;
        start_cls     = byte_class(start_b);
        start_tok     = tok_kind(start_b);
        start_en      = cmd.resume
                        || (cmd.accept && !halted_reg && !cont_num && !cont_name && !spill);
        start_to_tail = cmd.accept && (flush_num || flush_name);
    end

    assign stat.slot_free = slot_free;
    assign stat.spill     = !halted_reg && spill;
    assign stat.tail      = !halted_reg && (flush_num || flush_name) && (in_cls == CL_TOK);
    assign stat.emit_last = emit_last;

    always_comb begin
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        halted_next  = halted_reg;
        kw_int_next  = kw_int_reg;
        kw_if_next   = kw_if_reg;
        kw_else_next = kw_else_reg;
        hold_next    = hold_reg;
        tail_next    = tail_reg;
        ram_we       = 1'b0;
        ram_waddr    = len_reg[AW-1:0];
        ram_wdata    = s_tdata;
        load         = 1'b0;
        ld_kind      = K_ERROR;
        ld_num       = '0;
        ld_char      = '0;
        ld_last      = 1'b1;

        if (cmd.accept) begin
            if (halted_reg) begin
                load    = 1'b1;
                ld_kind = K_ERROR;
            end else if (cont_num) begin
                acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                           + {28'd0, s_tdata[3:0]};
            end else if (cont_name) begin
                ram_we   = 1'b1;
                len_next = LW'(len_reg + LW'(1));
                if (len_reg == LW'(1)) begin
                    kw_int_next  = kw_int_reg && (s_tdata == CH_N);
                    kw_if_next   = kw_if_reg && (s_tdata == CH_F);
                    kw_else_next = kw_else_reg && (s_tdata == CH_L);
                end else if (len_reg == LW'(2)) begin
                    kw_int_next  = kw_int_reg && (s_tdata == CH_T);
                    kw_if_next   = 1'b0;
                    kw_else_next = kw_else_reg && (s_tdata == CH_S);
                end else if (len_reg == LW'(3)) begin
                    kw_int_next  = 1'b0;
                    kw_if_next   = 1'b0;
                    kw_else_next = kw_else_reg && (s_tdata == CH_E);
                end else begin
                    kw_int_next  = 1'b0;
                    kw_if_next   = 1'b0;
                    kw_else_next = 1'b0;
                end
            end else if (spill) begin
                hold_next = s_tdata;
                idx_next  = '0;
            end else if (flush_num) begin
                load    = 1'b1;
                ld_kind = K_NUM;
                ld_num  = acc_reg;
            end else if (flush_name) begin
                load    = 1'b1;
                ld_kind = kw_kind;
            end
        end

        if (cmd.resume) begin
            len_next = '0;
        end

        if (start_en) begin
            mode_next = MODE_IDLE;
            case (start_cls)
                CL_DIG: begin
                    mode_next = MODE_NUM;
                    acc_next  = {28'd0, start_b[3:0]};
                end
                CL_ALPHA: begin
                    mode_next    = MODE_NAME;
                    ram_we       = 1'b1;
                    ram_waddr    = '0;
                    ram_wdata    = start_b;
                    len_next     = LW'(1);
                    kw_int_next  = (start_b == CH_I);
                    kw_if_next   = (start_b == CH_I);
                    kw_else_next = (start_b == CH_E);
                end
                CL_TOK: begin
                    if (start_to_tail) begin
                        tail_next = start_tok;
                    end else begin
                        load    = 1'b1;
                        ld_kind = start_tok;
                    end
                    if (start_tok == K_ERROR) begin
                        halted_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.tail_load) begin
            load    = 1'b1;
            ld_kind = tail_reg;
        end

        if (cmd.emit) begin
            load     = 1'b1;
            ld_kind  = K_NAME;
            ld_char  = ram_rdata;
            ld_last  = emit_last;
            idx_next = LW'(idx_reg + LW'(1));
        end

        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_kind_next  = load ? ld_kind : out_kind_reg;
        out_num_next   = load ? ld_num  : out_num_reg;
        out_char_next  = load ? ld_char : out_char_reg;
        out_last_next  = load ? ld_last : out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            acc_reg       <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            halted_reg    <= 1'b0;
            kw_int_reg    <= 1'b0;
            kw_if_reg     <= 1'b0;
            kw_else_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            halted_reg    <= halted_next;
            kw_int_reg    <= kw_int_next;
            kw_if_reg     <= kw_if_next;
            kw_else_reg   <= kw_else_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg     <= hold_next;
        tail_reg     <= tail_next;
        out_kind_reg <= out_kind_next;
        out_num_reg  <= out_num_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_char_reg, out_num_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/tlex_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlex_ctrl import tlex_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire tlex_stat_t stat,
    output tlex_cmd_t       cmd
);
    typedef enum logic [4:0] {
        ST_ACCEPT = 5'b00001,
        ST_TAIL   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_RESUME = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_ACCEPT: begin
                s_tready = stat.slot_free;
                if (s_tvalid && stat.slot_free) begin
                    cmd.accept = 1'b1;
                    if (stat.spill) begin
                        state_next = ST_READ;
                    end else if (stat.tail) begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                if (stat.slot_free) begin
                    cmd.tail_load = 1'b1;
                    state_next    = ST_ACCEPT;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.emit_last ? ST_RESUME : ST_READ;
                end
            end
            ST_RESUME: begin
                if (stat.slot_free) begin
                    cmd.resume = 1'b1;
                    state_next = ST_ACCEPT;
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/token_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | tdata bits (low to high)            | tuser     | tlast
// --------+-----+-------------------------------------+-----------+------------------
// s_      | in  | ch[7:0]                             | -         | -
// m_      | out | number_value[31:0] name_char[39:32] | kind[4:0] | last of the token
//
// Digits, name characters and whitespace are taken one byte per cycle while the result
// slot is free. A byte that closes a number or keyword and is itself a token is held
// and sent from the tail state. A plain name is sent from the name buffer one character
// at a time, each read through the registered port; the resume state then processes
// the byte that closed it. Reset is synchronous on aresetn; no clearing pass, the name
// buffer is written before read. A stalled m_tready holds the result register; input is
// taken while a result waits as long as the result slot frees in that cycle.

module token_lexer import tlex_pkg::*; #(
    parameter int MAX_NAME = 31
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input byte stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // ch[7:0]
    // token stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,    // number_value[31:0], name_char[39:32]
    output logic [TUSER_W-1:0]      m_tuser,    // kind[4:0]
    output logic                    m_tlast
);
    tlex_cmd_t  cmd;
    tlex_stat_t stat;

    // sequencer: accept, deferred token, name spill read/emit, resume
    tlex_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // token state, name buffer and result register
    tlex_datapath #(
        .MAX_NAME (MAX_NAME)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/tlex_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "token_lexer_defines.svh"

module tlex_checker import tlex_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [TUSER_W-1:0] m_tuser,
    input wire logic               m_tlast
);
    logic [4:0]           kind;
    logic                 in_xfer;
    logic                 out_stall;
    logic                 err_xfer;
    logic [TDATA_W+TUSER_W:0] out_bus;

    assign kind      = m_tuser;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign err_xfer  = m_tvalid && m_tready && (kind == K_ERROR) && !in_xfer;
    assign out_bus   = {m_tlast, m_tuser, m_tdata};

    `TLX_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall,
        m_tvalid && $stable(out_bus), "result changed while stalled")
    `TLX_ASSERT_SAME(a_nonlast_name, aclk, aresetn, m_tvalid && !m_tlast,
        kind == K_NAME, "only name characters may be non-final")
    `TLX_ASSERT_SAME(a_num_zero, aclk, aresetn, m_tvalid && (kind != K_NUM),
        m_tdata[31:0] == 32'd0, "number value set on a non-number")
    `TLX_ASSERT_SAME(a_char_zero, aclk, aresetn, m_tvalid && (kind != K_NAME),
        m_tdata[39:32] == 8'd0, "name char set on a non-name")
    `TLX_ASSERT_NEXT(a_err_sticky, aclk, aresetn, err_xfer,
        !m_tvalid || (kind == K_ERROR), "result after error is not an error")

endmodule

bind token_lexer tlex_checker u_tlex_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
